/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by mbe_ctrl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

/* src/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types and constants of the mandelbrot escape iteration unit
// ----------------------------------------------------------------------------
package mbe_pkg;

  // fixed field widths
  localparam int COUNT_W     = 16;
  localparam int LIMIT_W     = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // width of one multiplier operand slice
  localparam int CHUNK_W = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_LIMIT   = 1'd1;

  // register reset values
  localparam logic [COUNT_W-1:0] MAX_ITERATIONS_RESET = 16'd1000;
  localparam logic [LIMIT_W-1:0] ESCAPE_LIMIT_RESET   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic advance;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_last;
    logic finish;
  } status_t;

endpackage

/* src/mbe_point_if.sv */
// ----------------------------------------------------------------------------
// mbe_point_if
// channel carrying one complex point c
// ----------------------------------------------------------------------------
interface mbe_point_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] c_real;
  logic signed [DATA_WIDTH-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

/* src/mbe_count_if.sv */
// ----------------------------------------------------------------------------
// mbe_count_if
// channel carrying one iteration count
// ----------------------------------------------------------------------------
interface mbe_count_if;
  import mbe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

/* src/mbe_datapath.sv */
// ----------------------------------------------------------------------------
// mbe_datapath
// z registers, sliced multipliers, escape test and z update
// ----------------------------------------------------------------------------
module mbe_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mbe_pkg::cmd_t                       cmd,
  output mbe_pkg::status_t                    status,
  input  logic signed [DATA_WIDTH-1:0]        c_real,
  input  logic signed [DATA_WIDTH-1:0]        c_imag,
  input  logic [mbe_pkg::COUNT_W-1:0]         max_iterations,
  input  logic [mbe_pkg::LIMIT_W-1:0]         escape_limit,
  output logic [mbe_pkg::COUNT_W-1:0]         iteration_count
);
  import mbe_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int AW     = 2 * DW;
  localparam int SW     = AW + 2;
  localparam int NCHUNK = (DW + CHUNK_W - 1) / CHUNK_W;
  localparam int BW     = NCHUNK * CHUNK_W;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int MW     = DW + CHUNK_W + 1;
  localparam int CMPW   = (AW + 1 > 2 * FRAC_BITS + LIMIT_W) ? AW + 1
                                                            : 2 * FRAC_BITS + LIMIT_W;
  localparam logic [CIW-1:0]         CHUNK_TOP = CIW'(NCHUNK - 1);
  localparam logic [AW:0]            MAG_MAX   = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [SW-1:0]   WORD_MAX  = SW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [SW-1:0]   WORD_MIN  = ~WORD_MAX;

  function automatic logic signed [DW-1:0] sat_word(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_MAX[DW-1:0];
    end else if (v < WORD_MIN) begin
      r = WORD_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  logic signed [DW-1:0]  cr, ci;
  logic signed [DW-1:0]  zr, zi;
  logic [COUNT_W-1:0]    count;
  logic [CIW-1:0]        chunk;
  logic signed [AW-1:0]  p_rr, p_ii, p_ri;

  // multiplier slices, top slice signed, lower slices unsigned
  logic [BW-1:0]             zr_ext, zi_ext;
  logic [CHUNK_W-1:0]        sel_r, sel_i;
  logic signed [CHUNK_W:0]   slice_r, slice_i;
  logic signed [MW-1:0]      prod_rr, prod_ii, prod_ri;
  logic                      first;

  always_comb begin
    zr_ext  = BW'(zr);
    zi_ext  = BW'(zi);
    sel_r   = zr_ext[chunk*CHUNK_W +: CHUNK_W];
    sel_i   = zi_ext[chunk*CHUNK_W +: CHUNK_W];
    first   = (chunk == CHUNK_TOP);
    slice_r = first ? {sel_r[CHUNK_W-1], sel_r} : {1'b0, sel_r};
    slice_i = first ? {sel_i[CHUNK_W-1], sel_i} : {1'b0, sel_i};
    prod_rr = zr * slice_r;
    prod_ii = zi * slice_i;
    prod_ri = zr * slice_i;
  end

  // escape test and next z
  logic [AW:0]            mag_sum, mag_sat;
  logic [CMPW-1:0]        limit;
  logic                   escape;
  logic signed [AW:0]     re_diff, re_shift;
  logic signed [AW-1:0]   im_shift;
  logic signed [SW-1:0]   re_sum, im_sum;
  logic signed [DW-1:0]   zr_next, zi_next;

  always_comb begin
    mag_sum  = {1'b0, p_rr} + {1'b0, p_ii};
    mag_sat  = (mag_sum > MAG_MAX) ? MAG_MAX : mag_sum;
    limit    = CMPW'(escape_limit) << (2 * FRAC_BITS);
    escape   = CMPW'(mag_sat) >= limit;
    re_diff  = (AW+1)'(p_rr) - (AW+1)'(p_ii);
    re_shift = re_diff >>> FRAC_BITS;
    im_shift = p_ri >>> (FRAC_BITS - 1);
    re_sum   = SW'(re_shift) + SW'(cr);
    im_sum   = SW'(im_shift) + SW'(ci);
    zr_next  = sat_word(re_sum);
    zi_next  = sat_word(im_sum);
  end

  assign status.finish   = escape || (count >= max_iterations);
  assign status.mul_last = (chunk == '0);

  // slice index stops at the lowest slice so it never points past the word
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= CHUNK_TOP;
    end else if (cmd.load || cmd.advance) begin
      chunk <= CHUNK_TOP;
    end else if (cmd.mul_step && !status.mul_last) begin
      chunk <= chunk - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= c_real;
      ci    <= c_imag;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.advance) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= COUNT_W'(count + 1'b1);
    end
    if (cmd.mul_step) begin
      p_rr <= (first ? AW'(0) : (p_rr << CHUNK_W)) + AW'(prod_rr);
      p_ii <= (first ? AW'(0) : (p_ii << CHUNK_W)) + AW'(prod_ii);
      p_ri <= (first ? AW'(0) : (p_ri << CHUNK_W)) + AW'(prod_ri);
    end
    if (cmd.emit) begin
      iteration_count <= count;
    end
  end

endmodule

/* src/mbe_ctrl.sv */
// ----------------------------------------------------------------------------
// mbe_ctrl
// sequencer for one point: multiply slices, test, update, hand off result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mbe_pkg::cmd_t    cmd,
  input  mbe_pkg::status_t status
);
  import mbe_pkg::*;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.finish) begin
          // hold here while the previous result is still unclaimed
          if (slot_free) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_MUL;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_CLK(a_emit_on_finish, clk, rst, cmd.emit |-> (state == ST_UPDATE && status.finish), "result emitted before iteration finished")
  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.emit && out_valid && !out_ready, "pending result overwritten")
  `ASSERT_CLK(a_emit_then_valid, clk, rst, cmd.emit |=> out_valid, "emitted result not presented")
  `ASSERT_CLK(a_load_then_busy, clk, rst, cmd.load |=> (state == ST_MUL && !in_ready), "point accepted while busy")

endmodule

/* src/mandelbrot_escape_iteration_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration_unit
// escape-time iteration count for one complex point per transaction
// ----------------------------------------------------------------------------
// usage
//   point  : valid/ready sink, c_real and c_imag in signed fixed point
//            (FRAC_BITS fraction bits in a DATA_WIDTH-bit word)
//   result : valid/ready source, iteration_count of steps z = z*z + c done
//   cfg    : write port, index 0 max_iterations, index 1 escape_limit
//            (write only while no point is in flight)
// sequencing
//   one point is worked on at a time; an iteration is made of
//   NCHUNK = ceil(DATA_WIDTH / 32) slice steps through the three multipliers
//   plus one update step for the escape test and the new z
// reset
//   sequencer goes idle, result channel empties, max_iterations = 1000 and
//   escape_limit = 4
// stall
//   the result sits in an output register; a new point is accepted while it
//   waits, and only the hand-off of the next result holds until it is taken
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  mbe_point_if.sink                           point,
  mbe_count_if.source                         result,
  input  logic                                cfg_we,
  input  logic [mbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mbe_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0] max_iterations;
  logic [LIMIT_W-1:0] escape_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITERATIONS_RESET;
      escape_limit   <= ESCAPE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[COUNT_W-1:0];
        REG_ESCAPE_LIMIT:   escape_limit   <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller and datapath talk only through these two groups
  cmd_t    cmd;
  status_t status;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // z registers, sliced products, escape test, saturating z update
  mbe_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .c_real          (point.c_real),
    .c_imag          (point.c_imag),
    .max_iterations  (max_iterations),
    .escape_limit    (escape_limit),
    .iteration_count (result.iteration_count)
  );

endmodule
